// ----- rtl/rletc_pkg.sv -----
// rletc_pkg: types and constants shared by the run-length true-color decoder
// depends on nothing; imported by rletc_conv, rletc_parse and the top level
`default_nettype none

package rletc_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned COUNT_W = 18;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TCOLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TMSB  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd3;

  localparam logic [2:0] BPP_MIN = 3'd2;
  localparam logic [2:0] BPP_MAX = 3'd4;
  localparam logic [2:0] BPP_RESET = 3'd3;
  localparam logic [COUNT_W-1:0] TOTAL_RESET = 18'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 18'h3FFFF;

  localparam int unsigned HDR_RUN_BIT = 7;
  localparam logic [15:0] OPAQUE_BIT = 16'h8000;

  typedef struct packed {
    logic [2:0]         bpp;
    logic [14:0]        tcolor;
    logic               tmsb;
    logic [COUNT_W-1:0] total;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] pixel;
    logic [7:0]  run;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/rletc_conv.sv -----
// rletc_conv: pixel bytes to rgb555 with opaque flag and transparent-color check
// depends on rletc_pkg
`default_nettype none

module rletc_conv
  import rletc_pkg::*;
(
  input  wire logic [23:0] pixel_bytes,
  input  wire logic        is_bgr16,
  input  wire cfg_t        cfg,
  output logic      [15:0] pixel
);

  logic [14:0] v;
  logic [14:0] p;

  always_comb begin
    v = pixel_bytes[14:0];
    if (is_bgr16) begin
      // swap red and blue fields, drop bit 15
      p = {v[4:0], v[9:5], v[14:10]};
    end else begin
      p = {pixel_bytes[7:3], pixel_bytes[15:11], pixel_bytes[23:19]};
    end
    if (p == cfg.tcolor) begin
      pixel = cfg.tmsb ? OPAQUE_BIT : 16'h0000;
    end else begin
      pixel = OPAQUE_BIT | {1'b0, p};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rletc_parse.sv -----
// rletc_parse: packet header tracking, pixel byte assembly and pixel counting
// depends on rletc_pkg and rletc_conv
`default_nettype none

module rletc_parse
  import rletc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  logic               expect_header;
  logic               run_packet;
  logic [7:0]         pixels_left;
  logic [1:0]         byte_in_pixel;
  logic [23:0]        pixel_bytes;
  logic [COUNT_W-1:0] pixels_done;

  logic               expect_header_next;
  logic               run_packet_next;
  logic [7:0]         pixels_left_next;
  logic [1:0]         byte_in_pixel_next;
  logic [23:0]        pixel_bytes_next;
  logic [COUNT_W-1:0] pixels_done_next;

  logic [2:0]         eff_bpp;
  logic [23:0]        merged;
  logic               pixel_complete;
  logic [15:0]        conv_pixel;
  logic [7:0]         count;
  logic               packet_end;
  logic [COUNT_W:0]   done_sum;
  logic [COUNT_W-1:0] done_sat;

  always_comb begin
    if (cfg.bpp < BPP_MIN) begin
      eff_bpp = BPP_MIN;
    end else if (cfg.bpp > BPP_MAX) begin
      eff_bpp = BPP_MAX;
    end else begin
      eff_bpp = cfg.bpp;
    end
  end

  // fold the incoming byte into the pixel; a fourth byte (alpha) is dropped
  always_comb begin
    case (byte_in_pixel)
      2'd0: merged = pixel_bytes | {16'h0000, data_byte};
      2'd1: merged = pixel_bytes | {8'h00, data_byte, 8'h00};
      2'd2: merged = pixel_bytes | {data_byte, 16'h0000};
      default: merged = pixel_bytes;
    endcase
  end

  assign pixel_complete = ({1'b0, byte_in_pixel} + 3'd1) >= eff_bpp;

  rletc_conv u_conv (
    .pixel_bytes (merged),
    .is_bgr16    (eff_bpp == BPP_MIN),
    .cfg         (cfg),
    .pixel       (conv_pixel)
  );

  always_comb begin
    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    pixels_left_next   = pixels_left;
    byte_in_pixel_next = byte_in_pixel;
    pixel_bytes_next   = pixel_bytes;
    pixels_done_next   = pixels_done;
    res                = '0;
    count              = run_packet ? pixels_left : 8'd1;
    packet_end         = run_packet || (pixels_left == 8'd1);
    done_sum           = {1'b0, pixels_done} + {{(COUNT_W-7){1'b0}}, count};
    done_sat           = done_sum[COUNT_W] ? COUNT_MAX : done_sum[COUNT_W-1:0];

    if (expect_header) begin
      expect_header_next = 1'b0;
      run_packet_next    = data_byte[HDR_RUN_BIT];
      pixels_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
      byte_in_pixel_next = 2'd0;
      pixel_bytes_next   = 24'h0;
    end else if (!pixel_complete) begin
      byte_in_pixel_next = byte_in_pixel + 2'd1;
      pixel_bytes_next   = merged;
    end else begin
      byte_in_pixel_next = 2'd0;
      pixel_bytes_next   = 24'h0;
      pixels_left_next   = run_packet ? 8'd0 : pixels_left - 8'd1;
      pixels_done_next   = done_sat;
      res.valid          = 1'b1;
      res.pixel          = conv_pixel;
      res.run            = count;
      if (packet_end) begin
        expect_header_next = 1'b1;
        if (done_sat >= cfg.total) begin
          res.last         = 1'b1;
          pixels_done_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      pixels_left   <= 8'd0;
      byte_in_pixel <= 2'd0;
      pixel_bytes   <= 24'h0;
      pixels_done   <= '0;
    end else if (accept) begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      pixels_left   <= pixels_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_bytes   <= pixel_bytes_next;
      pixels_done   <= pixels_done_next;
    end
  end

  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid && res.last) |=> (pixels_done == '0 && expect_header))
    else $error("pixel count not cleared after last beat of image");

  a_header_no_result: assert property (@(posedge clk) disable iff (rst)
    expect_header |-> !res.valid)
    else $error("result produced from a header beat");

  a_run_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid && run_packet) |=> expect_header)
    else $error("run packet did not end after its pixel");

endmodule

`default_nettype wire

// ----- rtl/rle_true_color_pixel_decoder.sv -----
// a pixel's result is registered and valid in the cycle after the beat with its final byte
// one data byte per cycle unless stalled; header and partial-pixel bytes give no result
// a held result blocks every byte until the pixel side takes it; both can move together
// synchronous active-high reset: configuration to defaults, next byte is a header
// rle_true_color_pixel_decoder: top level with config registers and result register
// depends on rletc_pkg and rletc_parse
`default_nettype none

module rle_true_color_pixel_decoder
  import rletc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            data_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [15:0]           pixel_value,
  output logic      [7:0]            run_length,
  output logic                       last_of_image
);

  cfg_t    cfg;
  result_t res;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bpp    <= BPP_RESET;
      cfg.tcolor <= 15'h0;
      cfg.tmsb   <= 1'b0;
      cfg.total  <= TOTAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BPP:    cfg.bpp    <= cfg_data[2:0];
        CFG_TCOLOR: cfg.tcolor <= cfg_data[14:0];
        CFG_TMSB:   cfg.tmsb   <= cfg_data[0];
        CFG_TOTAL:  cfg.total  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rletc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      pixel_value   <= res.pixel;
      run_length    <= res.run;
      last_of_image <= res.last;
    end
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length != 8'd0)
    else $error("result beat with zero run length");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("byte accepted while result register is stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid) |=> out_valid)
    else $error("result lost on its way to the output register");

endmodule

`default_nettype wire
